[hw/rtl/tcq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcq_pkg;

   // Request action codes
   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_CONSUME = 2'd1;
   localparam logic [1:0] ACT_CLEANUP = 2'd2;

   // Reset value of the expiry age
   localparam logic [15:0] TTL_RESET = 16'd5000;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  command_kind;
      logic [15:0] time_now;
   } req_type;

   typedef struct packed {
      logic       succeeded;
      logic [3:0] expired_count;
      logic [3:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] stamp;
   } entry_type;

endpackage

`default_nettype wire

[hw/rtl/timed_command_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ring queue of up to QUEUE_DEPTH timestamped commands. An enqueue request appends
// a kind and time at the tail (fails when full); a consume request finds the first
// entry of a kind from the head, moves the head entry into its slot and pops the
// head; a cleanup request drops every entry whose age (time_now - stamp, mod 2^16)
// is at least csr_write_data's last written value, keeping survivors in order.
// Entries live in one single-port-read memory, so scans walk it one entry at a
// time. The finish state stretches while an earlier response still waits
// unaccepted in the output register. Requests are taken only while no request
// is in work; a finished response waits in the output register while the next
// request is accepted. Time-to-live resets to 5000.
module timed_command_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire tcq_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output tcq_pkg::rsp_type    rsp_data,
   input  wire                 csr_write_enable,
   input  wire  [15:0]         csr_write_data
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IW-1:0] LAST_POS = IW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos);
      if (pos == LAST_POS) begin
         return '0;
      end
      return pos + 1'b1;
   endfunction

   // Entry storage
   tcq_pkg::entry_type mem_ff [QUEUE_DEPTH];
   tcq_pkg::entry_type rd_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   tcq_pkg::entry_type mem_wdata;

   state_type          state_ff, state_in;
   logic [1:0]         action_ff, action_in;
   logic [2:0]         kind_ff, kind_in;
   logic [15:0]        now_ff, now_in;
   logic [15:0]        ttl_ff, ttl_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [IW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]      scan_cnt_ff, scan_cnt_in;
   logic [IW-1:0]      dest_ff, dest_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic [CW-1:0]      removed_ff, removed_in;
   logic               found_ff, found_in;
   tcq_pkg::entry_type head_entry_ff, head_entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tcq_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [15:0]        age;
   logic [CW+3:0]      removed_ext;
   logic [CW+3:0]      total_ext;

   assign age         = now_ff - rd_ff.stamp;
   assign removed_ext = {4'b0, removed_ff};
   assign total_ext   = {4'b0, total_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequence one request through the memory
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      ttl_in        = ttl_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      total_in      = total_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_cnt_in   = scan_cnt_ff;
      dest_in       = dest_ff;
      kept_in       = kept_ff;
      removed_in    = removed_ff;
      found_in      = found_ff;
      head_entry_in = head_entry_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = tail_ff;
      mem_wdata     = rd_ff;

      if (csr_write_enable) begin
         ttl_in = csr_write_data;
      end

      // Drop the response once taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in   = req_data.action;
               kind_in     = req_data.command_kind;
               now_in      = req_data.time_now;
               scan_ptr_in = head_ff;
               scan_cnt_in = '0;
               dest_in     = head_ff;
               kept_in     = '0;
               removed_in  = '0;
               found_in    = 1'b0;
               state_in    = ST_FINISH;
               if (req_data.action == tcq_pkg::ACT_ENQUEUE) begin
                  if (total_ff < FULL_COUNT) begin
                     mem_we          = 1'b1;
                     mem_waddr       = tail_ff;
                     mem_wdata.kind  = req_data.command_kind;
                     mem_wdata.stamp = req_data.time_now;
                     tail_in         = ring_next(tail_ff);
                     total_in        = total_ff + 1'b1;
                     found_in        = 1'b1;
                  end
               end else if (req_data.action == tcq_pkg::ACT_CONSUME ||
                            req_data.action == tcq_pkg::ACT_CLEANUP) begin
                  state_in = ST_READ;
               end
            end
         end

         ST_READ: begin
            if (scan_cnt_ff == total_ff) begin
               // Scan exhausted: a cleanup pulls the tail back behind the survivors
               if (action_ff == tcq_pkg::ACT_CLEANUP) begin
                  total_in = kept_ff;
                  tail_in  = dest_ff;
                  found_in = 1'b1;
               end
               state_in = ST_FINISH;
            end else begin
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            scan_ptr_in = ring_next(scan_ptr_ff);
            scan_cnt_in = scan_cnt_ff + 1'b1;
            state_in    = ST_READ;
            if (action_ff == tcq_pkg::ACT_CONSUME) begin
               if (scan_cnt_ff == '0) begin
                  head_entry_in = rd_ff;
               end
               if (rd_ff.kind == kind_ff) begin
                  // Move the head entry into the matched slot, then pop the head
                  mem_we    = (scan_cnt_ff != '0);
                  mem_waddr = scan_ptr_ff;
                  mem_wdata = head_entry_ff;
                  head_in   = ring_next(head_ff);
                  total_in  = total_ff - 1'b1;
                  found_in  = 1'b1;
                  state_in  = ST_FINISH;
               end
            end else begin
               if (age >= ttl_ff) begin
                  removed_in = removed_ff + 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = dest_ff;
                  mem_wdata = rd_ff;
                  dest_in   = ring_next(dest_ff);
                  kept_in   = kept_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            // Load the response when the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.succeeded     = found_ff;
               rsp_data_in.expired_count = removed_ext[3:0];
               rsp_data_in.occupancy     = total_ext[3:0];
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ttl_ff       <= tcq_pkg::TTL_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ttl_ff       <= ttl_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      kind_ff       <= kind_in;
      now_ff        <= now_in;
      scan_ptr_ff   <= scan_ptr_in;
      scan_cnt_ff   <= scan_cnt_in;
      dest_ff       <= dest_in;
      kept_ff       <= kept_in;
      removed_ff    <= removed_in;
      found_ff      <= found_in;
      head_entry_ff <= head_entry_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Write and read the entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem_ff[scan_ptr_ff];
   end

endmodule

`default_nettype wire

[tb/sv/timed_command_queue_test.sv]
`timescale 1ns / 1ps

module timed_command_queue_test;

   localparam int DEPTH = 8;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int PHASE_REQUESTS = 180;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tcq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tcq_pkg::rsp_type rsp_data;
   logic             csr_write_enable;
   logic [15:0]      csr_write_data;

   // shadow copy of the ring and the expiry age
   tcq_pkg::entry_type slot [DEPTH];
   int unsigned      head_pos;
   int unsigned      tail_pos;
   int unsigned      held;
   logic [15:0]      ttl;

   tcq_pkg::rsp_type outcomes [$];
   int unsigned      failures;
   bit               calm;
   logic [15:0]      tick;

   timed_command_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, now and then a long one; none while calm
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // advance the shadow ring by one request and return the response it owes
   function automatic tcq_pkg::rsp_type apply_request(tcq_pkg::req_type r);
      tcq_pkg::rsp_type   o;
      tcq_pkg::entry_type e;
      int unsigned p;
      int unsigned d;
      int unsigned kept;
      logic [15:0] age;
      o = '0;
      case (r.action)
         tcq_pkg::ACT_ENQUEUE: begin
            if (held < DEPTH) begin
               slot[tail_pos].kind  = r.command_kind;
               slot[tail_pos].stamp = r.time_now;
               tail_pos = (tail_pos + 1) % DEPTH;
               held++;
               o.succeeded = 1'b1;
            end
         end
         tcq_pkg::ACT_CONSUME: begin
            for (int i = 0; i < held; i++) begin
               p = (head_pos + i) % DEPTH;
               if (slot[p].kind == r.command_kind) begin
                  e = slot[p];
                  slot[p] = slot[head_pos];
                  slot[head_pos] = e;
                  head_pos = (head_pos + 1) % DEPTH;
                  held--;
                  o.succeeded = 1'b1;
                  break;
               end
            end
         end
         tcq_pkg::ACT_CLEANUP: begin
            kept = 0;
            for (int i = 0; i < held; i++) begin
               p = (head_pos + i) % DEPTH;
               age = r.time_now - slot[p].stamp;
               if (age >= ttl) begin
                  o.expired_count = o.expired_count + 4'd1;
               end else begin
                  d = (head_pos + kept) % DEPTH;
                  slot[d] = slot[p];
                  kept++;
               end
            end
            held = kept;
            tail_pos = (head_pos + kept) % DEPTH;
            o.succeeded = 1'b1;
         end
         default: begin
         end
      endcase
      o.occupancy = 4'(held);
      return o;
   endfunction

   // present one request at a falling edge, hold it until taken, then sometimes idle a while
   task automatic send_request(input logic [1:0] action, input logic [2:0] kind,
                               input logic [15:0] stamp);
      int unsigned gap;
      req_data.action       = action;
      req_data.command_kind = kind;
      req_data.time_now     = stamp;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      outcomes.push_back(apply_request(req_data));
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // drop valid and wait until every response is back and the scan is over
   task automatic settle();
      req_valid = 1'b0;
      while (outcomes.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_ttl(input logic [15:0] value);
      settle();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      ttl = value;
   endtask

   task automatic test_empty_queue();
      send_request(tcq_pkg::ACT_CONSUME, 3'd0, 16'd0);
      send_request(tcq_pkg::ACT_CLEANUP, 3'd7, 16'hFFFF);
      send_request(ACT_UNUSED, 3'd5, 16'd1234);
   endtask

   // fill every slot, overflow once, then hit twice and miss once
   task automatic test_fill_and_consume();
      logic [15:0] stamps [8];
      stamps = '{16'd0, 16'hFFFF, 16'd1, 16'd4999, 16'd5000, 16'h8000, 16'h7FFF, 16'd2500};
      for (int k = 0; k < DEPTH; k++) send_request(tcq_pkg::ACT_ENQUEUE, 3'(k), stamps[k]);
      send_request(tcq_pkg::ACT_ENQUEUE, 3'd5, 16'd42);
      send_request(tcq_pkg::ACT_CONSUME, 3'd3, 16'd10);
      send_request(tcq_pkg::ACT_CONSUME, 3'd0, 16'd11);
      send_request(tcq_pkg::ACT_CONSUME, 3'd3, 16'd12);
      send_request(ACT_UNUSED, 3'd2, 16'h5555);
   endtask

   // ages on both sides of the reset age, across the wrap, then a zero age limit
   task automatic test_expiry_edges();
      send_request(tcq_pkg::ACT_CLEANUP, 3'd0, 16'd5000);
      write_ttl(16'd0);
      send_request(tcq_pkg::ACT_ENQUEUE, 3'd6, 16'hAAAA);
      send_request(tcq_pkg::ACT_CLEANUP, 3'd1, 16'hAAAA);
   endtask

   // well-formed traffic on a slowly moving clock, with some noise mixed in
   task automatic test_random_traffic();
      logic [15:0] plan [6];
      logic [1:0]  action;
      logic [2:0]  kind;
      logic [15:0] stamp;
      int unsigned span;
      int unsigned roll;
      plan = '{16'd1, 16'hFFFF, 16'd0, 16'd40, 16'd5000, 16'd0};
      plan[5] = 16'($urandom_range(2, 65534));
      for (int ph = 0; ph < 6; ph++) begin
         write_ttl(plan[ph]);
         span = $urandom_range(0, 1) ? 7 : 2;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
            tick  = tick + 16'($urandom_range(0, ttl / 4 + 3));
            kind  = 3'($urandom_range(0, span));
            stamp = tick;
            roll  = $urandom_range(0, 99);
            if (roll < 4) begin
               action = 2'($urandom_range(0, 3));
               kind   = 3'($urandom_range(0, 7));
               stamp  = 16'($urandom);
            end else if (roll < 48) begin
               action = tcq_pkg::ACT_ENQUEUE;
            end else if (roll < 75) begin
               action = tcq_pkg::ACT_CONSUME;
            end else if (roll < 96) begin
               action = tcq_pkg::ACT_CLEANUP;
            end else begin
               action = ACT_UNUSED;
            end
            send_request(action, kind, stamp);
         end
         calm = 1'b0;
      end
   endtask

   // response side: ready with random stalls
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic note_mismatch(input string field, input int want, input int got);
      failures++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   // compare each taken response with the oldest outstanding prediction
   always @(posedge clock) begin
      tcq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcomes.size() == 0) begin
            failures++;
            $display("%0t: unexpected response expected none actual %h", $time, rsp_data);
         end else begin
            want = outcomes.pop_front();
            if (rsp_data.succeeded !== want.succeeded)
               note_mismatch("succeeded", want.succeeded, rsp_data.succeeded);
            if (rsp_data.expired_count !== want.expired_count)
               note_mismatch("expired_count", want.expired_count, rsp_data.expired_count);
            if (rsp_data.occupancy !== want.occupancy)
               note_mismatch("occupancy", want.occupancy, rsp_data.occupancy);
         end
      end
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      failures         = 0;
      calm             = 1'b0;
      tick             = '0;
      head_pos         = 0;
      tail_pos         = 0;
      held             = 0;
      ttl              = tcq_pkg::TTL_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_fill_and_consume();
      test_expiry_edges();
      test_random_traffic();
      settle();

      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
